// File: hw/rtl/edm_pkg.sv
`timescale 1ns / 1ps

package edm_pkg;

    localparam int unsigned SYM_W  = 8;
    localparam int unsigned COST_W = 8;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned CFG_W  = 64;
    localparam int unsigned IDX_W  = 2;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_REF_CHARS_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_REF_CHARS_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] CFG_REF_LENGTH     = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_DISTANCE   = 2'd3;

    localparam logic [COST_W-1:0] MAX_DISTANCE_RST = 8'd3;
    localparam logic [COST_W-1:0] COST_SAT         = 8'hFF;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             empty_query;
    } request_t;

    typedef struct packed {
        logic [COST_W-1:0] distance;
        logic              prefix_related;
        logic              within_limit;
    } result_t;

    // token handed from cell to cell along the row
    typedef struct packed {
        logic              valid;
        logic [SYM_W-1:0]  symbol;
        logic              last;
        logic              empty_query;
        logic [LEN_W-1:0]  len;
        logic              prefix;
        logic [COST_W-1:0] cost_new;
        logic [COST_W-1:0] cost_old;
        logic [COST_W-1:0] result_cost;
    } wave_t;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        return (v == COST_SAT) ? v : v + 8'd1;
    endfunction

endpackage

// File: hw/rtl/edm_cell.sv
`timescale 1ns / 1ps

module edm_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [edm_pkg::SYM_W-1:0]   ref_byte,
    input  edm_pkg::wave_t              wave_in,
    output edm_pkg::wave_t              wave_out
);
    import edm_pkg::*;

    localparam logic [COST_W-1:0] CLEAR_COST = COST_W'(CELL_IDX + 1);
    localparam logic [LEN_W-1:0]  CELL_LEN   = LEN_W'(CELL_IDX + 1);

    logic [COST_W-1:0] cost_reg, cost_next;
    wave_t             wave_reg, wave_next;
    logic [COST_W-1:0] ins_cost, del_cost, sub_cost, min_id, min_all;

    always_comb begin
        ins_cost = sat_inc(wave_in.cost_new);
        del_cost = sat_inc(cost_reg);
        sub_cost = (wave_in.symbol == ref_byte) ? wave_in.cost_old
                                                : sat_inc(wave_in.cost_old);
        min_id   = (ins_cost < del_cost) ? ins_cost : del_cost;
        min_all  = (sub_cost < min_id) ? sub_cost : min_id;

        wave_next          = wave_in;
        wave_next.cost_new = min_all;
        wave_next.cost_old = cost_reg;
        if (!wave_in.empty_query && (wave_in.len == CELL_LEN)) begin
            wave_next.result_cost = min_all;
        end

        cost_next = cost_reg;
        if (wave_in.valid) begin
            if (wave_in.empty_query || wave_in.last) begin
                cost_next = CLEAR_COST;
            end else begin
                cost_next = min_all;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg       <= CLEAR_COST;
            wave_reg.valid <= 1'b0;
        end else if (advance) begin
            cost_reg <= cost_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

// File: hw/rtl/edit_distance_matcher_unit.sv
`timescale 1ns / 1ps

// edit distance matcher
// compares a query string against a reference word of up to MAX_REF_LEN bytes
// - s_ channel: one request per query byte; last marks the final byte,
//   empty_query stands for a whole empty query and carries no byte
// - m_ channel: one result per last or empty request: distance, prefix flag
//   and close-enough flag against max_distance
// - cfg port: reference bytes, reference length and max_distance; the user must
//   see that it is written only while no request is in flight (not enforced)
// the cost row lives in a row of MAX_REF_LEN cells; a request enters an entry stage,
// then walks one cell per cycle when not stalled: a skewed wave updates the row
// path: a request passes the entry stage, the cells and the output register
// throughput: one request per cycle while s_ready is high, set by the one-cell-per-cycle wave
// reset: cost row, query count and prefix flag go to their cleared values,
// the reference is empty and max_distance is 3; m_valid drops
// stall: the output register holds a waiting result; requests keep flowing
// until a second result reaches the row's end, then the whole row holds and
// s_ready drops until m_ready takes the waiting one

module edit_distance_matcher_unit #(
    parameter int unsigned MAX_REF_LEN = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_we,
    input  logic [edm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [edm_pkg::CFG_W-1:0]    cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  edm_pkg::request_t            s_data,

    output logic                         m_valid,
    input  logic                         m_ready,
    output edm_pkg::result_t             m_data
);
    import edm_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]  ref_low_reg;
    logic [CFG_W-1:0]  ref_high_reg;
    logic [LEN_W-1:0]  ref_length_reg;
    logic [COST_W-1:0] max_distance_reg;
    logic [2*CFG_W-1:0] ref_chars;

    // matching state kept at the entry of the row
    logic [COST_W-1:0] count_reg, count_next;
    logic              agree_reg, agree_next;

    logic [LEN_W-1:0]  len_eff;
    logic [SYM_W-1:0]  count_byte;
    logic              mismatch;
    logic              agree_now;
    logic [COST_W-1:0] count_inc;

    logic              accept;
    logic              advance;
    logic              tail_has_result;

    wave_t             wave0_reg, wave0_next;
    wave_t             waves [MAX_REF_LEN+1];

    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;

    assign ref_chars = {ref_high_reg, ref_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_low_reg      <= '0;
            ref_high_reg     <= '0;
            ref_length_reg   <= '0;
            max_distance_reg <= MAX_DISTANCE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_REF_CHARS_LOW:  ref_low_reg      <= cfg_wdata;
                CFG_REF_CHARS_HIGH: ref_high_reg     <= cfg_wdata;
                CFG_REF_LENGTH:     ref_length_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_MAX_DISTANCE:   max_distance_reg <= cfg_wdata[COST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // row stalls only when a second result meets a full output reg and !m_ready
    assign tail_has_result = waves[MAX_REF_LEN].valid &&
                             (waves[MAX_REF_LEN].last || waves[MAX_REF_LEN].empty_query);
    assign advance = !(tail_has_result && m_valid_reg && !m_ready);
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // entry stage: prefix check, query count and column zero of the row
    always_comb begin
        len_eff    = (ref_length_reg > LEN_W'(MAX_REF_LEN)) ? LEN_W'(MAX_REF_LEN)
                                                            : ref_length_reg;
        // count only matters while below len_eff, so its low nibble is enough
        count_byte = ref_chars[{count_reg[3:0], 3'b000} +: SYM_W];
        mismatch   = (count_reg < COST_W'(len_eff)) && (s_data.symbol != count_byte);
        agree_now  = agree_reg && !mismatch;
        count_inc  = sat_inc(count_reg);

        wave0_next             = '0;
        wave0_next.valid       = accept;
        wave0_next.symbol      = s_data.symbol;
        wave0_next.last        = s_data.last;
        wave0_next.empty_query = s_data.empty_query;
        wave0_next.len         = len_eff;
        // column zero always equals the query count
        wave0_next.cost_old    = count_reg;
        wave0_next.cost_new    = count_inc;
        if (s_data.empty_query) begin
            // empty query reports the reference length with both flags clear
            wave0_next.prefix      = 1'b0;
            wave0_next.result_cost = COST_W'(len_eff);
        end else begin
            wave0_next.prefix      = agree_now;
            wave0_next.result_cost = (len_eff == '0) ? count_inc : '0;
        end

        count_next = count_reg;
        agree_next = agree_reg;
        if (accept) begin
            if (s_data.empty_query || s_data.last) begin
                count_next = '0;
                agree_next = 1'b1;
            end else begin
                count_next = count_inc;
                agree_next = agree_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            agree_reg       <= 1'b1;
            wave0_reg.valid <= 1'b0;
        end else begin
            count_reg <= count_next;
            agree_reg <= agree_next;
            if (advance) begin
                wave0_reg <= wave0_next;
            end
        end
    end

    assign waves[0] = wave0_reg;

    // row of cells, cell j holds cost row entry j+1
    for (genvar j = 0; j < MAX_REF_LEN; j++) begin : g_cell
        edm_cell #(
            .CELL_IDX (j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .ref_byte (ref_chars[j*SYM_W +: SYM_W]),
            .wave_in  (waves[j]),
            .wave_out (waves[j+1])
        );
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && tail_has_result) begin
            m_valid_next               = 1'b1;
            m_data_next.distance       = waves[MAX_REF_LEN].result_cost;
            m_data_next.prefix_related = waves[MAX_REF_LEN].prefix;
            m_data_next.within_limit   = !waves[MAX_REF_LEN].empty_query &&
                                         (waves[MAX_REF_LEN].result_cost <= max_distance_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/edm_checker.sv
`timescale 1ns / 1ps

module edm_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              m_valid,
    input  logic              m_ready,
    input  edm_pkg::result_t  m_data
);
    import edm_pkg::*;

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending right after reset");

    // a waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("waiting result changed or dropped");

    // the input side only blocks behind a result the receiver is not taking
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request blocked without an output stall");

    // with a close-enough result shown and m_ready high, a waiting request is taken
    a_within_needs_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.within_limit && s_valid |-> s_ready || !m_ready)
        else $error("within_limit seen while input blocked with receiver ready");

endmodule

bind edit_distance_matcher_unit edm_checker u_edm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
